### hdl/two_opt_tour_move_engine_macros.svh
// Assertion macros used by the tour move engine.
`ifndef TWO_OPT_TOUR_MOVE_ENGINE_MACROS_SVH
`define TWO_OPT_TOUR_MOVE_ENGINE_MACROS_SVH

// Checked only outside reset.
`define TMVE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define TMVE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/tmve_pkg.sv
`timescale 1ns / 1ps

package tmve_pkg;

  localparam int MAX_NODES_DEF  = 256;
  localparam int DIST_WIDTH_DEF = 16;
  localparam int NODE_W         = 8;
  localparam int IDX_W          = 8;
  localparam int LEN_W          = 9;
  localparam int LOAD_W         = 16;
  localparam int DELTA_W        = 18;
  localparam int OP_W           = 3;
  localparam int DIST_ADDR_W    = 2 * NODE_W;

  localparam logic [OP_W-1:0] OP_LOAD_TOUR = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD_DIST = 3'd1;
  localparam logic [OP_W-1:0] OP_EVAL      = 3'd2;
  localparam logic [OP_W-1:0] OP_APPLY     = 3'd3;
  localparam logic [OP_W-1:0] OP_READ      = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [IDX_W-1:0]  first_index;
    logic [IDX_W-1:0]  second_index;
    logic [LOAD_W-1:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DELTA_W-1:0] cost_delta;
    logic [NODE_W-1:0]         node_read;
    logic                      error_flag;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic en;
    logic sub;
  } acc_ctl_t;

endpackage

### hdl/tmve_delta_acc.sv
`timescale 1ns / 1ps

module tmve_delta_acc import tmve_pkg::*; #(
  parameter int DIST_WIDTH = DIST_WIDTH_DEF
) (
  input  logic                      clk,
  input  acc_ctl_t                  ctl,
  input  logic [DIST_WIDTH-1:0]     dist_in,
  output logic signed [DELTA_W-1:0] delta
);

  localparam int ACC_W = DIST_WIDTH + 3;
  localparam int SAT_W = (ACC_W > DELTA_W) ? ACC_W : DELTA_W;
  localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(2 ** (DELTA_W - 1) - 1);
  localparam logic signed [SAT_W-1:0] SAT_MIN = SAT_W'(-(2 ** (DELTA_W - 1)));

  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;
  logic signed [ACC_W-1:0] term;
  logic signed [SAT_W-1:0] acc_wide;

  assign term = signed'(ACC_W'(dist_in));

  always_comb begin
    acc_nxt = acc_r;
    priority if (ctl.clear) begin
      acc_nxt = '0;
    end else if (ctl.en) begin
      acc_nxt = ctl.sub ? (acc_r - term) : (acc_r + term);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc_wide = SAT_W'(acc_r);

  always_comb begin
    priority if (acc_wide > SAT_MAX) begin
      delta = DELTA_W'(SAT_MAX);
    end else if (acc_wide < SAT_MIN) begin
      delta = DELTA_W'(SAT_MIN);
    end else begin
      delta = DELTA_W'(acc_wide);
    end
  end

endmodule

### hdl/two_opt_tour_move_engine.sv
`timescale 1ns / 1ps
// 2-opt move engine over a cyclic tour held in a tour memory and a distance matrix memory.
// Input channel in_valid/in_ready/in_data carries one command per transaction: load a tour
// entry, load a distance, evaluate the cost change of a move, apply a move, or read a tour
// entry. Each command yields exactly one result transaction on out_valid/out_ready/out_data.
// The tour length register is written over cfg_valid/cfg_ready/cfg_data; the user must do so
// only while idle, which the block does not enforce. The block works on one command at a time;
// in_ready is high only when it is idle. An apply makes s swaps, where s is floor((j-i)/2),
// at most 127. A new command is taken in the cycle after the result is registered. Apply time
// is set by the single read and write port of the tour memory: each swap needs two reads and
// two writes, which overlap. Evaluate reads four tour entries and four distances through the
// same read ports, with one shared add/subtract unit accumulating the change.
// Reset (synchronous, active low) clears the sequencer and the output valid, and sets the
// tour length to 256; both memories hold no defined contents until written.
// A stalled receiver leaves the result in the output register; the engine may take the
// next command meanwhile but holds its result until the output register is free.
module two_opt_tour_move_engine import tmve_pkg::*; #(
  parameter int MAX_NODES  = MAX_NODES_DEF,
  parameter int DIST_WIDTH = DIST_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LEN_W-1:0] cfg_data
);

  `include "two_opt_tour_move_engine_macros.svh"

  localparam int TW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW0   = $clog2(MAX_NODES + 1);
  localparam int CW    = (CW0 > LEN_W) ? CW0 : LEN_W;
  localparam int DEPTH = 1 << DIST_ADDR_W;
  localparam int KW    = 3;
  localparam logic [KW-1:0] K_LAST = 3'd4;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_WAIT     = 9'b000000010,
    S_EV_T     = 9'b000000100,
    S_EV_D     = 9'b000001000,
    S_SW_RD_LO = 9'b000010000,
    S_SW_RD_HI = 9'b000100000,
    S_SW_WR_LO = 9'b001000000,
    S_SW_WR_HI = 9'b010000000,
    S_RESP     = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [DIST_WIDTH-1:0] dist_mem [DEPTH];

  logic [NODE_W-1:0]      tour_rdata_r;
  logic [DIST_WIDTH-1:0]  dist_rdata_r;
  logic                   tour_we;
  logic [TW-1:0]          tour_wa;
  logic [TW-1:0]          tour_ra;
  logic [NODE_W-1:0]      tour_wd;
  logic                   dist_we;
  logic [DIST_ADDR_W-1:0] dist_ra;

  logic [LEN_W-1:0]  tour_length_r;
  logic [OP_W-1:0]   op_r;
  logic              err_r;
  logic [TW-1:0]     pos_r [4];
  logic [NODE_W-1:0] node_r [4];
  logic [KW-1:0]     k_r, k_nxt;
  logic [TW-1:0]     lo_r, hi_r;
  logic [NODE_W-1:0] tmp_r;
  logic              more_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic              in_fire;
  logic              resp_fire;
  logic [CW-1:0]     n_w, i_w, j_w, jn_w;
  logic              err_w;
  out_item_t         res;
  acc_ctl_t          acc_ctl;
  logic signed [DELTA_W-1:0] delta;

  logic [NODE_W-1:0] tour_ram [MAX_NODES];

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Decode of the incoming command.
  assign n_w  = (CW'(tour_length_r) > CW'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(tour_length_r);
  assign i_w  = CW'(in_data.first_index);
  assign j_w  = CW'(in_data.second_index);
  assign jn_w = (CW'(j_w + CW'(1)) == n_w) ? '0 : CW'(j_w + CW'(1));

  always_comb begin
    unique case (in_data.opcode)
      OP_LOAD_TOUR, OP_READ: err_w = (i_w >= n_w);
      OP_LOAD_DIST:          err_w = 1'b0;
      OP_EVAL, OP_APPLY:     err_w = (i_w >= n_w) || (j_w >= n_w) ||
                                     (j_w < CW'(i_w + CW'(2)));
      default:               err_w = 1'b1;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    unique case (state_r)
      S_IDLE: begin
        k_nxt = '0;
        if (in_fire) begin
          if (err_w) begin
            state_nxt = S_RESP;
          end else begin
            unique case (in_data.opcode)
              OP_EVAL:  state_nxt = S_EV_T;
              OP_APPLY: state_nxt = S_SW_RD_LO;
              OP_READ:  state_nxt = S_WAIT;
              default:  state_nxt = S_RESP;
            endcase
          end
        end
      end
      S_WAIT: state_nxt = S_RESP;
      S_EV_T: begin
        if (k_r == K_LAST) begin
          k_nxt     = '0;
          state_nxt = S_EV_D;
        end else begin
          k_nxt = k_r + KW'(1);
        end
      end
      S_EV_D: begin
        if (k_r == K_LAST) begin
          state_nxt = S_RESP;
        end else begin
          k_nxt = k_r + KW'(1);
        end
      end
      S_SW_RD_LO: state_nxt = S_SW_RD_HI;
      S_SW_RD_HI: state_nxt = S_SW_WR_LO;
      S_SW_WR_LO: state_nxt = S_SW_WR_HI;
      S_SW_WR_HI: state_nxt = more_r ? S_SW_WR_LO : S_RESP;
      S_RESP: begin
        if (resp_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      k_r           <= '0;
      tour_length_r <= LEN_W'(256);
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      if (cfg_valid && cfg_ready) begin
        tour_length_r <= cfg_data;
      end
    end
  end

  // Command registers and swap bookkeeping.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r     <= in_data.opcode;
      err_r    <= err_w;
      pos_r[0] <= i_w[TW-1:0];
      pos_r[1] <= CW'(i_w + CW'(1)) >= CW'(MAX_NODES) ? '0 : TW'(i_w + CW'(1));
      pos_r[2] <= j_w[TW-1:0];
      pos_r[3] <= jn_w[TW-1:0];
      lo_r     <= TW'(i_w + CW'(1));
      hi_r     <= j_w[TW-1:0];
    end
    if (state_r == S_EV_T && k_r != '0) begin
      node_r[2'(k_r - KW'(1))] <= tour_rdata_r;
    end
    if (state_r == S_SW_RD_HI) begin
      tmp_r <= tour_rdata_r;
    end
    if (state_r == S_SW_WR_LO) begin
      more_r <= (TW'(hi_r - lo_r) > TW'(2));
    end
    if (state_r == S_SW_WR_HI) begin
      tmp_r <= tour_rdata_r;
      if (more_r) begin
        lo_r <= lo_r + TW'(1);
        hi_r <= hi_r - TW'(1);
      end
    end
  end

  // Tour memory ports: one write and one read a cycle.
  always_comb begin
    tour_we = 1'b0;
    tour_wa = i_w[TW-1:0];
    tour_wd = in_data.load_value[NODE_W-1:0];
    tour_ra = pos_r[0];
    unique case (state_r)
      S_IDLE: begin
        tour_we = in_fire && !err_w && (in_data.opcode == OP_LOAD_TOUR);
        tour_wa = i_w[TW-1:0];
      end
      S_EV_T: begin
        if (k_r != K_LAST) begin
          tour_ra = pos_r[k_r[1:0]];
        end
      end
      S_SW_RD_LO: tour_ra = lo_r;
      S_SW_RD_HI: tour_ra = hi_r;
      S_SW_WR_LO: begin
        tour_we = 1'b1;
        tour_wa = lo_r;
        tour_wd = tour_rdata_r;
        tour_ra = lo_r + TW'(1);
      end
      S_SW_WR_HI: begin
        tour_we = 1'b1;
        tour_wa = hi_r;
        tour_wd = tmp_r;
        tour_ra = hi_r - TW'(1);
      end
      default: tour_ra = pos_r[0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (tour_we) begin
      tour_ram[tour_wa] <= tour_wd;
    end
    tour_rdata_r <= tour_ram[tour_ra];
  end

  // Distance memory: written by distance loads, read four times per evaluation.
  assign dist_we = in_fire && (in_data.opcode == OP_LOAD_DIST);

  always_comb begin
    unique case (k_r)
      3'd0:    dist_ra = {node_r[1], node_r[3]};
      3'd1:    dist_ra = {node_r[0], node_r[2]};
      3'd2:    dist_ra = {node_r[0], node_r[1]};
      default: dist_ra = {node_r[2], node_r[3]};
    endcase
  end

  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[{in_data.first_index, in_data.second_index}] <=
        DIST_WIDTH'(in_data.load_value);
    end
    dist_rdata_r <= dist_mem[dist_ra];
  end

  // Shared add/subtract unit.
  always_comb begin
    acc_ctl.clear = (state_r == S_EV_D) && (k_r == '0);
    acc_ctl.en    = (state_r == S_EV_D) && (k_r != '0);
    acc_ctl.sub   = (k_r >= KW'(3));
  end

  tmve_delta_acc #(
    .DIST_WIDTH(DIST_WIDTH)
  ) u_delta_acc (
    .clk    (clk),
    .ctl    (acc_ctl),
    .dist_in(dist_rdata_r),
    .delta  (delta)
  );

  // Result and output register.
  always_comb begin
    res.error_flag = err_r;
    res.cost_delta = (!err_r && op_r == OP_EVAL) ? delta : '0;
    res.node_read  = (!err_r && op_r == OP_READ) ? tour_rdata_r : '0;
  end

  assign resp_fire = (state_r == S_RESP) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (resp_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_fire) begin
      out_data_r <= res;
    end
  end

  `TMVE_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "accepted a second transaction while busy")
  `TMVE_ASSERT(a_swap_no_collide, ((state_r == S_SW_WR_LO) || (state_r == S_SW_WR_HI)) |-> (tour_wa != tour_ra), "swap reads the entry it writes")
  `TMVE_ASSERT(a_swap_order, ((state_r == S_SW_WR_LO) || (state_r == S_SW_WR_HI)) |-> (lo_r < hi_r), "swap pointers crossed")
  `TMVE_ASSERT(a_step_range, ((state_r == S_EV_T) || (state_r == S_EV_D)) |-> (k_r <= K_LAST), "evaluation step out of range")
  `TMVE_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "output valid after reset")

endmodule
